>>> rtl/iss_pkg.sv
// iss_pkg: shared types and constants for the indexed sequence store
// action and status codes, data width and default capacity
// no dependencies
package iss_pkg;

  localparam int DATA_W       = 32;
  localparam int CAPACITY_DEF = 64;
  localparam int ACTION_W     = 3;
  localparam int STATUS_W     = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_READ_AT    = 3'd4,
    ACT_INSERT_AT  = 3'd5,
    ACT_REMOVE_AT  = 3'd6
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

endpackage

>>> rtl/iss_mem.sv
// iss_mem: element storage, one write port and one read port
// read data is registered, valid the cycle after the read request
// depends on iss_pkg for the data width
module iss_mem import iss_pkg::*; #(
  parameter int DEPTH  = CAPACITY_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     wen,
  input  logic [ADDR_W-1:0]        waddr,
  input  logic signed [DATA_W-1:0] wdata,
  input  logic                     ren,
  input  logic [ADDR_W-1:0]        raddr,
  output logic signed [DATA_W-1:0] rdata
);

  logic signed [DATA_W-1:0] store [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      store[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ren) begin
      rdata <= store[raddr];
    end
  end

endmodule

>>> rtl/iss_ctrl.sv
// iss_ctrl: request decode, bounds checks and the shift sequencer
// one shared cursor stepper walks the gap open or closed, one element per step
// depends on iss_pkg; drives the ports of iss_mem
module iss_ctrl import iss_pkg::*; #(
  parameter  int CAPACITY = CAPACITY_DEF,
  localparam int CNT_W    = $clog2(CAPACITY + 1),
  localparam int ADDR_W   = $clog2(CAPACITY)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [ACTION_W-1:0]      action,
  input  logic [CNT_W-1:0]         position,
  input  logic signed [DATA_W-1:0] data_in,
  output logic                     done,
  output logic signed [DATA_W-1:0] data_out,
  output logic [STATUS_W-1:0]      status,
  output logic [CNT_W-1:0]         count,
  output logic                     mem_wen,
  output logic [ADDR_W-1:0]        mem_waddr,
  output logic signed [DATA_W-1:0] mem_wdata,
  output logic                     mem_ren,
  output logic [ADDR_W-1:0]        mem_raddr,
  input  logic signed [DATA_W-1:0] mem_rdata
);

  typedef enum logic [7:0] {
    S_IDLE       = 8'b0000_0001,
    S_DECODE     = 8'b0000_0010,
    S_FETCH      = 8'b0000_0100,
    S_FETCH_WAIT = 8'b0000_1000,
    S_STEP       = 8'b0001_0000,
    S_MOVE_RD    = 8'b0010_0000,
    S_MOVE_WR    = 8'b0100_0000,
    S_REPLY      = 8'b1000_0000
  } state_t;

  state_t                   state;
  logic [ACTION_W-1:0]      act;
  logic [CNT_W-1:0]         pos;
  logic signed [DATA_W-1:0] din;
  logic [CNT_W-1:0]         n;
  logic [ADDR_W-1:0]        cursor;
  logic [ADDR_W-1:0]        limit;
  logic [ADDR_W-1:0]        tgt;
  logic                     dir_up;
  logic                     placing;
  logic signed [DATA_W-1:0] dout;
  status_t                  st;

  // decode results
  status_t                  dec_status;
  logic [CNT_W-1:0]         dec_tgt;
  logic                     dec_put;
  logic                     dec_take;
  logic                     dec_read;
  logic                     full;
  logic                     empty;
  logic [CNT_W-1:0]         n_last;

  // shared stepper
  logic [ADDR_W-1:0]        nbr;
  logic                     at_limit;

  assign full     = (n == CNT_W'(CAPACITY));
  assign empty    = (n == '0);
  assign n_last   = n - CNT_W'(1);
  assign nbr      = dir_up ? cursor + ADDR_W'(1) : cursor - ADDR_W'(1);
  assign at_limit = (cursor == limit);

  always_comb begin
    dec_status = ST_OK;
    dec_tgt    = '0;
    dec_put    = 1'b0;
    dec_take   = 1'b0;
    dec_read   = 1'b0;
    case (act) inside
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (full) begin
          dec_status = ST_FULL;
        end else begin
          dec_put = 1'b1;
          dec_tgt = (act == ACT_PUSH_FRONT) ? '0 : n;
        end
      end
      ACT_POP_FRONT, ACT_POP_BACK: begin
        if (empty) begin
          dec_status = ST_EMPTY;
        end else begin
          dec_take = 1'b1;
          dec_tgt  = (act == ACT_POP_FRONT) ? '0 : n_last;
        end
      end
      ACT_READ_AT, ACT_REMOVE_AT: begin
        if (empty) begin
          dec_status = ST_EMPTY;
        end else if (pos >= n) begin
          dec_status = ST_RANGE;
        end else begin
          dec_read = (act == ACT_READ_AT);
          dec_take = (act == ACT_REMOVE_AT);
          dec_tgt  = pos;
        end
      end
      ACT_INSERT_AT: begin
        if (pos > n) begin
          dec_status = ST_RANGE;
        end else if (full) begin
          dec_status = ST_FULL;
        end else begin
          dec_put = 1'b1;
          dec_tgt = pos;
        end
      end
      default: begin
        dec_status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      n     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            act   <= action;
            pos   <= position;
            din   <= data_in;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          st   <= dec_status;
          dout <= '0;
          tgt  <= dec_tgt[ADDR_W-1:0];
          if (dec_put) begin
            cursor  <= n[ADDR_W-1:0];
            limit   <= dec_tgt[ADDR_W-1:0];
            dir_up  <= 1'b0;
            placing <= 1'b1;
            state   <= S_STEP;
          end else if (dec_take || dec_read) begin
            state <= S_FETCH;
          end else begin
            state <= S_REPLY;
          end
        end
        S_FETCH: begin
          state <= S_FETCH_WAIT;
        end
        S_FETCH_WAIT: begin
          dout <= mem_rdata;
          if (act == ACT_READ_AT) begin
            state <= S_REPLY;
          end else begin
            cursor  <= tgt;
            limit   <= n_last[ADDR_W-1:0];
            dir_up  <= 1'b1;
            placing <= 1'b0;
            state   <= S_STEP;
          end
        end
        S_STEP: begin
          if (at_limit) begin
            if (placing) begin
              // gap is open at the target, the write happens in this cycle
              n <= n + CNT_W'(1);
            end else begin
              n <= n_last;
            end
            state <= S_REPLY;
          end else begin
            state <= S_MOVE_RD;
          end
        end
        S_MOVE_RD: begin
          state <= S_MOVE_WR;
        end
        S_MOVE_WR: begin
          cursor <= nbr;
          state  <= S_STEP;
        end
        S_REPLY: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    mem_ren   = (state == S_FETCH) || (state == S_MOVE_RD);
    mem_raddr = (state == S_FETCH) ? tgt : nbr;
    mem_wen   = (state == S_MOVE_WR) || ((state == S_STEP) && at_limit && placing);
    mem_waddr = (state == S_MOVE_WR) ? cursor : tgt;
    mem_wdata = (state == S_MOVE_WR) ? mem_rdata : din;
  end

  assign busy     = (state != S_IDLE);
  assign done     = (state == S_REPLY);
  assign data_out = dout;
  assign status   = st;
  assign count    = n;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    n <= CNT_W'(CAPACITY))
    else $error("element count beyond capacity");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held longer than one cycle");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (count == CNT_W'(CAPACITY)))
    else $error("full reported on a store with room");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_EMPTY) |-> (count == '0))
    else $error("empty reported on a non-empty store");

  a_count_moves_once: assert property (@(posedge clk) disable iff (rst)
    (busy && !done && $past(busy) && (n != $past(n))) |=> done)
    else $error("count changed before the final step");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_wen |-> ({1'b0, mem_waddr} <= n))
    else $error("element write beyond the end of the sequence");
`endif

endmodule

>>> rtl/indexed_sequence_store.sv
// Indexed sequence store: an ordered list of up to CAPACITY signed 32-bit
// values with push and pop at either end, and read, insert and remove at a
// position. A request is taken when start is high and busy is low; busy
// then stays high until the single result has been shown on data_out,
// status and count for one cycle with done high. The receiver cannot stall,
// so the result must be captured in that cycle. Elements sit in one memory
// with one write and one registered read port, and inserts and removes move
// the later elements one at a time under a shared cursor stepper; each element
// moved passes through the step, move-read and move-write states.
//
// top level; depends on iss_pkg, iss_mem and iss_ctrl
module indexed_sequence_store import iss_pkg::*; #(
  parameter  int CAPACITY = CAPACITY_DEF,
  localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [ACTION_W-1:0]      action,
  input  logic [CNT_W-1:0]         position,
  input  logic signed [DATA_W-1:0] data_in,
  output logic                     done,
  output logic signed [DATA_W-1:0] data_out,
  output logic [STATUS_W-1:0]      status,
  output logic [CNT_W-1:0]         count
);

  localparam int ADDR_W = $clog2(CAPACITY);

  logic                     mem_wen;
  logic [ADDR_W-1:0]        mem_waddr;
  logic signed [DATA_W-1:0] mem_wdata;
  logic                     mem_ren;
  logic [ADDR_W-1:0]        mem_raddr;
  logic signed [DATA_W-1:0] mem_rdata;

  iss_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .action    (action),
    .position  (position),
    .data_in   (data_in),
    .done      (done),
    .data_out  (data_out),
    .status    (status),
    .count     (count),
    .mem_wen   (mem_wen),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_ren   (mem_ren),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  iss_mem #(
    .DEPTH  (CAPACITY),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .wen   (mem_wen),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .ren   (mem_ren),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
